### src/ipeth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipeth_pkg: shared types and constants of the IP stream to Ethernet framer
// Holds the command word that the parser hands to the frame emitter, the
// Ethernet and IP constants, and the register defaults.
// ----------------------------------------------------------------------------
package ipeth_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEST_MAC  = 2'd0;
  localparam logic [1:0] REG_SRC_MAC   = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME = 2'd2;

  // Register defaults.
  localparam logic [47:0] DEST_MAC_RESET  = 48'h0000_0000_0000;
  localparam logic [47:0] SRC_MAC_RESET   = 48'hB691_24A8_1472;
  localparam logic [15:0] MAX_FRAME_RESET = 16'd1514;

  // Protocol constants.
  localparam logic [7:0]  VERSION_MASK  = 8'hF0;
  localparam logic [7:0]  VERSION_FOUR  = 8'h40;
  localparam logic [7:0]  VERSION_SIX   = 8'h60;
  localparam logic [16:0] V6_FIXED_HDR  = 17'd40;
  localparam logic [17:0] ETH_HDR_BYTES = 18'd14;
  localparam logic [15:0] ETYPE_V4      = 16'h0800;
  localparam logic [15:0] ETYPE_V6      = 16'h86DD;

  // Emitter word positions: header of 14, then 4 or 6 held bytes.
  localparam logic [4:0] LAST_POS_V4 = 5'd17;
  localparam logic [4:0] LAST_POS_V6 = 5'd19;

  // Default depth of the command queue.
  localparam int CMD_DEPTH_DEFAULT = 4;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_HDR  = 1'b1
  } cmd_kind_t;

  // One command from the parser to the emitter. For CMD_DATA the word is in
  // hold[7:0]; for CMD_HDR hold carries the header bytes, first byte on top.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        v6;
    logic        last;
    logic [47:0] hold;
  } cmd_t;

endpackage

### src/ipeth_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipeth_parser: packet delineation front end
// Takes one stream word per cycle while in_take is high, tracks where each
// IP packet starts and ends, and makes at most one emitter command per word.
// ----------------------------------------------------------------------------
module ipeth_parser
  import ipeth_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_take,
  input  logic [7:0]  data_byte,
  input  logic        chunk_end,
  input  logic [15:0] max_frame,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_STREAM  = 5'b00100,
    PH_SKIP    = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  hold [6];
  logic [2:0]  seen, seen_next;
  logic [16:0] plen, plen_next;
  logic        v6, v6_next;

  logic [2:0]  seen_inc;
  logic [2:0]  need;
  logic [16:0] pkt_len;
  logic [16:0] rest;
  logic        too_long;
  logic        short_v4;
  logic        hdr_done;
  logic [16:0] plen_dec;

  // Length arithmetic on the word that completes the length field.
  always_comb begin
    seen_inc = seen + 3'd1;
    need     = v6 ? 3'd6 : 3'd4;
    hdr_done = (seen_inc == need);
    if (v6) begin
      pkt_len = V6_FIXED_HDR + {1'b0, hold[4], data_byte};
    end else begin
      pkt_len = {1'b0, hold[2], data_byte};
    end
    short_v4 = !v6 && (pkt_len < 17'd4);
    rest     = pkt_len - {14'd0, need};
    too_long = ({1'b0, pkt_len} + ETH_HDR_BYTES) > {2'd0, max_frame};
    plen_dec = plen - 17'd1;
  end

  // Next state and command generation.
  always_comb begin
    phase_next = phase;
    seen_next  = seen;
    plen_next  = plen;
    v6_next    = v6;
    cmd_valid  = 1'b0;
    cmd.kind   = CMD_DATA;
    cmd.v6     = v6;
    cmd.last   = 1'b0;
    cmd.hold   = {40'd0, data_byte};
    if (in_take) begin
      unique case (phase)
        PH_IDLE: begin
          if ((data_byte & VERSION_MASK) == VERSION_FOUR) begin
            v6_next    = 1'b0;
            seen_next  = 3'd1;
            phase_next = PH_HEADER;
          end else if ((data_byte & VERSION_MASK) == VERSION_SIX) begin
            v6_next    = 1'b1;
            seen_next  = 3'd1;
            phase_next = PH_HEADER;
          end else begin
            seen_next  = 3'd0;
            plen_next  = 17'd0;
            phase_next = chunk_end ? PH_IDLE : PH_DISCARD;
          end
        end
        PH_HEADER: begin
          seen_next = seen_inc;
          if (hdr_done) begin
            seen_next = 3'd0;
            if (short_v4) begin
              plen_next  = 17'd0;
              phase_next = chunk_end ? PH_IDLE : PH_DISCARD;
            end else begin
              plen_next = rest;
              if (too_long) begin
                phase_next = (rest != 17'd0) ? PH_SKIP : PH_IDLE;
              end else begin
                phase_next = (rest != 17'd0) ? PH_STREAM : PH_IDLE;
                cmd_valid  = 1'b1;
                cmd.kind   = CMD_HDR;
                cmd.last   = (rest == 17'd0);
                if (v6) begin
                  cmd.hold = {hold[0], hold[1], hold[2], hold[3], hold[4], data_byte};
                end else begin
                  cmd.hold = {hold[0], hold[1], hold[2], data_byte, 16'd0};
                end
              end
            end
          end
        end
        PH_STREAM: begin
          plen_next = plen_dec;
          cmd_valid = 1'b1;
          cmd.last  = (plen_dec == 17'd0);
          if (plen_dec == 17'd0) begin
            phase_next = PH_IDLE;
          end
        end
        PH_SKIP: begin
          plen_next = plen_dec;
          if (plen_dec == 17'd0) begin
            phase_next = PH_IDLE;
          end
        end
        PH_DISCARD: begin
          if (chunk_end) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      seen  <= 3'd0;
      plen  <= 17'd0;
      v6    <= 1'b0;
    end else begin
      phase <= phase_next;
      seen  <= seen_next;
      plen  <= plen_next;
      v6    <= v6_next;
    end
  end

  // Header holding registers, written in arrival order.
  always_ff @(posedge clk) begin
    if (in_take && (phase == PH_IDLE)) begin
      hold[0] <= data_byte;
    end else if (in_take && (phase == PH_HEADER) && (seen < 3'd6)) begin
      hold[seen] <= data_byte;
    end
  end

endmodule

### src/ipeth_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipeth_cmd_queue: command queue between parser and emitter
// A small circular buffer that lets the parser keep taking words while the
// emitter works through a long header burst.
// ----------------------------------------------------------------------------
module ipeth_cmd_queue
  import ipeth_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_full,
  output logic q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign rd_cmd  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

### src/ipeth_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipeth_emitter: frame byte emitter back end
// Expands each queued command into output words: a header command becomes
// the Ethernet header plus the held IP header bytes, a data command one word.
// Drives the output register.
// ----------------------------------------------------------------------------
module ipeth_emitter
  import ipeth_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_ready,
  output logic        cmd_done,
  input  logic [47:0] dest_mac,
  input  logic [47:0] src_mac,
  input  logic        pop,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [4:0]        pos;
  logic              load;
  logic              step;
  logic              at_end;
  logic [4:0]        end_pos;
  logic [15:0]       etype;
  logic [19:0][7:0]  hdr_words;
  logic [7:0]        word;
  logic              word_last;

  // Pick the word at the current burst position.
  always_comb begin
    etype     = cmd.v6 ? ETYPE_V6 : ETYPE_V4;
    hdr_words = {dest_mac, src_mac, etype, cmd.hold};
    end_pos   = cmd.v6 ? LAST_POS_V6 : LAST_POS_V4;
    at_end    = (pos == end_pos);
    load      = !out_valid || pop;
    step      = load && cmd_ready;
    unique case (cmd.kind)
      CMD_HDR: begin
        word      = hdr_words[LAST_POS_V6 - pos];
        word_last = cmd.last && at_end;
        cmd_done  = step && at_end;
      end
      CMD_DATA: begin
        word      = cmd.hold[7:0];
        word_last = cmd.last;
        cmd_done  = step;
      end
      default: begin
        word      = cmd.hold[7:0];
        word_last = cmd.last;
        cmd_done  = step;
      end
    endcase
  end

  // Burst position within a header command.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 5'd0;
    end else if (cmd_done) begin
      pos <= 5'd0;
    end else if (step) begin
      pos <= pos + 5'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= cmd_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= word;
      out_last <= word_last;
    end
  end

endmodule

### src/ip_stream_to_ethernet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_stream_to_ethernet_framer: raw IP stream to Ethernet frames
// Finds IPv4 and IPv6 packet boundaries in a byte stream and emits each
// packet that fits behind a 14-byte Ethernet header.
//
//   channel  handshake               payload
//   input    push / full             data_byte, chunk_end
//   result   empty / pop             frame_byte, frame_last
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The parser takes one word per cycle while the command queue has room.
// Data words of a streamed packet leave through the emitter's output register;
// the word that completes a packet header expands into 18 (IPv4) or 20 (IPv6)
// output words, one per cycle while pop keeps up; the emitter sets the rate.
// Reset is synchronous and clears the parser state, queue and output register.
// A stalled pop holds the result; a full queue raises full.
// ----------------------------------------------------------------------------
module ip_stream_to_ethernet_framer
  import ipeth_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        chunk_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic        frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] dest_mac;
  logic [47:0] src_mac;
  logic [15:0] max_frame;

  logic in_take;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic q_full, q_empty;
  logic cmd_done;
  logic out_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_take   = push && !q_full;
  assign empty     = !out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_mac  <= DEST_MAC_RESET;
      src_mac   <= SRC_MAC_RESET;
      max_frame <= MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEST_MAC:  dest_mac  <= cfg_data;
        REG_SRC_MAC:   src_mac   <= cfg_data;
        REG_MAX_FRAME: max_frame <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  ipeth_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .data_byte (data_byte),
    .chunk_end (chunk_end),
    .max_frame (max_frame),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  ipeth_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_cmd  (cmd_in),
    .rd_en   (cmd_done),
    .rd_cmd  (cmd_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  ipeth_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_ready (!q_empty),
    .cmd_done  (cmd_done),
    .dest_mac  (dest_mac),
    .src_mac   (src_mac),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (frame_byte),
    .out_last  (frame_last)
  );

endmodule

### src/ipeth_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipeth_checker: port-level checks of the framer
// Watches the top-level ports for reset behavior and result holding.
// ----------------------------------------------------------------------------
module ipeth_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_byte,
  input logic       frame_last,
  input logic       cfg_ready
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // Reset leaves the input side open.
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input full right after reset");

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(frame_last)))
    else $error("waiting result changed before it was taken");

  // The configuration port never stalls outside reset.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind ip_stream_to_ethernet_framer ipeth_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .frame_byte (frame_byte),
  .frame_last (frame_last),
  .cfg_ready  (cfg_ready)
);

### tb/ip_stream_to_ethernet_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_stream_to_ethernet_framer_tb: self-checking bench for the IP framer
// Feeds raw IPv4/IPv6 byte streams through the push/full side, predicts the
// Ethernet-framed output word by word, and checks every popped word in order.
// Traffic mixes well-formed packets with short lengths, unknown versions and
// oversized packets, under several MAC and frame-size register settings, with
// bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module ip_stream_to_ethernet_framer_tb;
  import ipeth_pkg::*;

  // One raw input word and one framed output word.
  typedef struct packed {
    logic [7:0] data;
    logic       ends_chunk;
  } ip_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  typedef enum logic [2:0] {
    AWAIT_START,
    IN_HEADER,
    STREAMING,
    SKIPPING,
    DISCARDING
  } parse_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'd0;
  logic        chunk_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_DEST_MAC;
  logic [47:0] cfg_data = 48'd0;

  // Raw stream waiting to be offered, and framed words still owed by the block.
  ip_word_t    ip_stream[$];
  frame_word_t expected_frame[$];

  int words_queued = 0;
  int words_accepted = 0;
  int words_checked = 0;
  int frames_checked = 0;
  int settings_used = 1;
  int fail_count = 0;

  // Register shadow copies.
  logic [47:0] dest_mac_cfg = DEST_MAC_RESET;
  logic [47:0] src_mac_cfg = SRC_MAC_RESET;
  logic [15:0] max_frame_cfg = MAX_FRAME_RESET;

  // Parser shadow state.
  parse_state_t parse_state = AWAIT_START;
  logic [7:0]   held_hdr[6];
  int           hdr_count = 0;
  int           bytes_left = 0;
  logic         is_v6 = 1'b0;

  // Sender and receiver pacing.
  int burst_left = 0;
  int gap_left = 0;
  int window_left = 0;
  int stall_mode = 0;
  int hold_left = 0;

  ip_stream_to_ethernet_framer DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .chunk_end  (chunk_end),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void owe_word(input logic [7:0] b, input logic last);
    frame_word_t w;
    w.data = b;
    w.last = last;
    expected_frame.push_back(w);
  endfunction

  // Drops input until the chunk ends; a word that itself ends the chunk
  // returns the parser straight to the start of a packet.
  function automatic void drop_rest_of_chunk(input logic ends);
    hdr_count = 0;
    bytes_left = 0;
    parse_state = ends ? AWAIT_START : DISCARDING;
  endfunction

  // Advances the parser shadow by one accepted input word and queues every
  // framed word that it releases.
  function automatic void frame_ip_byte(input logic [7:0] b, input logic ends);
    int          need;
    int          len;
    int          rest;
    logic [15:0] etype;
    case (parse_state)
      AWAIT_START: begin
        if ((b & VERSION_MASK) == VERSION_FOUR) begin
          is_v6 = 1'b0;
        end else if ((b & VERSION_MASK) == VERSION_SIX) begin
          is_v6 = 1'b1;
        end else begin
          drop_rest_of_chunk(ends);
          return;
        end
        held_hdr[0] = b;
        hdr_count = 1;
        parse_state = IN_HEADER;
      end
      IN_HEADER: begin
        if (hdr_count < 6) held_hdr[hdr_count] = b;
        hdr_count++;
        need = is_v6 ? 6 : 4;
        if (hdr_count < need) return;
        if (is_v6) begin
          len = int'(V6_FIXED_HDR) + int'({held_hdr[4], held_hdr[5]});
        end else begin
          len = int'({held_hdr[2], held_hdr[3]});
          if (len < 4) begin
            drop_rest_of_chunk(ends);
            return;
          end
        end
        rest = len - need;
        hdr_count = 0;
        bytes_left = rest;
        // Oversized packets are skipped without output.
        if (len + int'(ETH_HDR_BYTES) > int'(max_frame_cfg)) begin
          parse_state = (rest != 0) ? SKIPPING : AWAIT_START;
          return;
        end
        for (int i = 0; i < 6; i++) owe_word(dest_mac_cfg[47 - 8 * i -: 8], 1'b0);
        for (int i = 0; i < 6; i++) owe_word(src_mac_cfg[47 - 8 * i -: 8], 1'b0);
        etype = is_v6 ? ETYPE_V6 : ETYPE_V4;
        owe_word(etype[15:8], 1'b0);
        owe_word(etype[7:0], 1'b0);
        for (int i = 0; i < need; i++) begin
          owe_word(held_hdr[i], (rest == 0) && (i == need - 1));
        end
        parse_state = (rest != 0) ? STREAMING : AWAIT_START;
      end
      STREAMING: begin
        if (bytes_left > 0) bytes_left--;
        owe_word(b, bytes_left == 0);
        if (bytes_left == 0) parse_state = AWAIT_START;
      end
      SKIPPING: begin
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) parse_state = AWAIT_START;
      end
      DISCARDING: begin
        if (ends) parse_state = AWAIT_START;
      end
      default: parse_state = AWAIT_START;
    endcase
  endfunction

  // Sender: offers queued words in bursts with random gaps between them.
  always @(posedge clk) begin : drive_input
    logic     offer;
    ip_word_t w;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        frame_ip_byte(data_byte, chunk_end);
        words_accepted++;
      end
      if (!push || !full) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (ip_stream.size() > 0) begin
          w = ip_stream.pop_front();
          data_byte <= w.data;
          chunk_end <= w.ends_chunk;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
        push <= offer;
      end
    end
  end

  // Receiver: checks each popped word and stalls on a changing pattern, with
  // two long hold-offs that let the block back up into its input.
  always @(posedge clk) begin : check_output
    frame_word_t want;
    logic        take;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_frame.size() == 0) begin
          $error("unexpected word: frame_byte %02h frame_last %0b", frame_byte, frame_last);
          fail_count++;
        end else begin
          want = expected_frame.pop_front();
          if (frame_byte !== want.data) begin
            $error("frame_byte mismatch: expected %02h, actual %02h", want.data, frame_byte);
            fail_count++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last mismatch: expected %0b, actual %0b", want.last, frame_last);
            fail_count++;
          end
        end
        words_checked++;
        if (frame_last) frames_checked++;
        if (words_checked == 100 || words_checked == 400) hold_left = 400;
      end
      if (window_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        window_left = $urandom_range(16, 96);
      end else begin
        window_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (stall_mode)
          0: take = 1'b1;
          1: take = ($urandom_range(0, 1) == 1);
          2: take = ($urandom_range(0, 3) == 0);
          default: take = ($urandom_range(0, 7) != 0);
        endcase
      end
      pop <= take;
    end
  end

  function automatic logic rand_end();
    return ($urandom_range(0, 5) == 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic ends);
    ip_word_t w;
    w.data = b;
    w.ends_chunk = ends;
    ip_stream.push_back(w);
    words_queued++;
  endtask

  // A few junk words, the last of them closing the chunk.
  task automatic send_junk_to_end();
    int n;
    n = $urandom_range(0, 4);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // IPv4 packet of the given total length; a length below four is broken
  // and is followed by junk up to the chunk end.
  task automatic send_v4(input int len);
    logic ends;
    send_byte({4'h4, 4'($urandom_range(0, 15))}, rand_end());
    send_byte(8'($urandom_range(0, 255)), rand_end());
    send_byte(len[15:8], rand_end());
    ends = rand_end();
    send_byte(len[7:0], ends);
    if (len < 4) begin
      if (!ends) send_junk_to_end();
    end else begin
      for (int i = 4; i < len; i++) send_byte(8'($urandom_range(0, 255)), rand_end());
    end
  endtask

  // IPv6 packet with the given payload length.
  task automatic send_v6(input int payload);
    send_byte({4'h6, 4'($urandom_range(0, 15))}, rand_end());
    repeat (3) send_byte(8'($urandom_range(0, 255)), rand_end());
    send_byte(payload[15:8], rand_end());
    send_byte(payload[7:0], rand_end());
    for (int i = 6; i < 40 + payload; i++) begin
      send_byte(8'($urandom_range(0, 255)), rand_end());
    end
  endtask

  task automatic send_unknown_version();
    logic [3:0] nib;
    logic       ends;
    do nib = 4'($urandom_range(0, 15)); while (nib == 4'h4 || nib == 4'h6);
    ends = rand_end();
    send_byte({nib, 4'($urandom_range(0, 15))}, ends);
    if (!ends) send_junk_to_end();
  endtask

  // Mostly well-formed packets with random content; the rest are broken headers,
  // unknown versions and, under a frame limit of 80 or less, near-limit packets.
  task automatic send_random_traffic(input int target);
    int start;
    int pick;
    int lim;
    start = words_queued;
    while (words_queued - start < target) begin
      pick = $urandom_range(0, 99);
      lim = int'(max_frame_cfg) - int'(ETH_HDR_BYTES);
      if (pick < 55) begin
        send_v4($urandom_range(4, 24));
      end else if (pick < 65) begin
        send_v4($urandom_range(0, 3));
      end else if (pick < 75) begin
        send_unknown_version();
      end else if (pick < 85) begin
        send_v6($urandom_range(0, 6));
      end else if (max_frame_cfg <= 16'd80) begin
        if ($urandom_range(0, 1) == 0) send_v4(lim - 1 + $urandom_range(0, 2));
        else if (lim >= 40) send_v6(lim - 40 + $urandom_range(0, 1));
        else send_v6($urandom_range(0, 1));
      end else begin
        send_v4($urandom_range(4, 12));
      end
    end
  endtask

  // Waits until every queued word is taken and every framed word has come
  // back, then lets skipped words settle inside the block.
  task automatic wait_until_drained();
    while (words_accepted != words_queued || expected_frame.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [47:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEST_MAC:  dest_mac_cfg = value;
      REG_SRC_MAC:   src_mac_cfg = value;
      REG_MAX_FRAME: max_frame_cfg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [47:0] dest, input logic [47:0] src,
                               input logic [15:0] max_frame);
    write_register(REG_DEST_MAC, dest);
    write_register(REG_SRC_MAC, src);
    write_register(REG_MAX_FRAME, {32'd0, max_frame});
    settings_used++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset register values.
    send_byte(8'h4F, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h45, 1'b0);
    send_byte(8'h60, 1'b1);
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'h45, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_junk_to_end();
    send_byte(8'h4A, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h05, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h70, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_v6(0);
    send_random_traffic(50);
    wait_until_drained();

    // Smallest frame limit with all-ones destination: most IPv6 is skipped.
    apply_setting(48'hFFFF_FFFF_FFFF, 48'h0, 16'd54);
    send_v6(0);
    send_v6(1);
    send_random_traffic(30);
    wait_until_drained();

    // Largest frame limit; every generated packet fits.
    apply_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 16'hFFFF);
    send_random_traffic(30);
    wait_until_drained();

    // Default-sized limit with fresh addresses.
    apply_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 16'd1514);
    send_random_traffic(25);
    wait_until_drained();

    // A small random limit.
    apply_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  16'($urandom_range(55, 80)));
    send_random_traffic(30);
    wait_until_drained();

    $display("Framed %0d packets (%0d output words) from %0d input words",
             frames_checked, words_checked, words_accepted);
    $display("across %0d register settings, with stalls on both sides", settings_used);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, well beyond the slowest expected run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
